>>> hdl/ise_pkg.sv
// Shared types and constants for the insertion sort engine.
`default_nettype none

package ise_pkg;

    // Element width and default store depth
    localparam int VALUE_W       = 32;
    localparam int DEPTH_DEFAULT = 64;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ise_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic insert;  // insert the incoming value into the sorted cells
        logic shift;   // move every cell one place toward the head
    } ise_cmd_t;

endpackage

`default_nettype wire

>>> hdl/ise_datapath.sv
// Datapath: row of sorted cells with parallel compare for insertion and shift-out.
`default_nettype none

module ise_datapath #(
    parameter int DEPTH = ise_pkg::DEPTH_DEFAULT,
    localparam int CountW = $clog2(DEPTH + 1)
) (
    input  wire logic                                aclk,
    input  wire ise_pkg::ise_cmd_t                   cmd,
    input  wire logic [CountW-1:0]                   fill_count,
    input  wire logic signed [ise_pkg::VALUE_W-1:0]  in_value,
    output logic signed [ise_pkg::VALUE_W-1:0]       head_value
);
    import ise_pkg::*;

    logic signed [VALUE_W-1:0] cell_reg  [DEPTH];
    logic signed [VALUE_W-1:0] cell_next [DEPTH];
    logic [DEPTH-1:0]          move_up;

    // A cell moves aside for the new value if it is empty or holds a larger value
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            move_up[i] = (CountW'(i) >= fill_count) || (cell_reg[i] > in_value);
        end
    end

    // Next cell contents: insertion, shift toward the head, or hold
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_next[i] = cell_reg[i];
            if (cmd.insert) begin
                if (i > 0 && move_up[(i > 0) ? i - 1 : 0]) begin
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                end else if (move_up[i]) begin
                    cell_next[i] = in_value;
                end
            end else if (cmd.shift) begin
                if (i < DEPTH - 1) begin
                    cell_next[i] = cell_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    // Cell registers (payload, no reset)
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign head_value = cell_reg[0];

endmodule

`default_nettype wire

>>> hdl/ise_ctrl.sv
// Controller: fill count, drop flag and the collect/emit state machine.
`default_nettype none

module ise_ctrl #(
    parameter int DEPTH = ise_pkg::DEPTH_DEFAULT,
    localparam int CountW = $clog2(DEPTH + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tlast,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic                     m_tlast,
    output logic                     overflow,
    output ise_pkg::ise_cmd_t        cmd,
    output logic [CountW-1:0]        fill_count
);
    import ise_pkg::*;

    ise_state_t        state_reg, state_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic              in_xfer;
    logic              out_xfer;
    logic              full;

    assign full     = (count_reg == CountW'(DEPTH));
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Next state and outputs
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (in_xfer) begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        cmd.insert = 1'b1;
                        count_next = count_reg + CountW'(1);
                    end
                    if (s_tlast) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (out_xfer) begin
                    cmd.shift  = 1'b1;
                    count_next = count_reg - CountW'(1);
                    if (count_reg == CountW'(1)) begin
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // Count doubles as the remaining-results counter while emitting
    assign m_tlast    = (count_reg == CountW'(1));
    assign overflow   = dropped_reg;
    assign fill_count = count_reg;

endmodule

`default_nettype wire

>>> hdl/insertion_sort_engine.sv
// Insertion sort engine: stable ascending sort of signed 32-bit values in sets.
// Throughput: one input transfer per cycle while a set is collected.
// The first result is valid in the cycle after the transfer marked last.
// While a set is emitted, input is held off until the set drains.
// Overflowing values are dropped and flagged on every result of that set.
// Reset (aresetn low, synchronous) empties the store and clears the drop flag.
`default_nettype none

module insertion_sort_engine #(
    parameter int DEPTH = ise_pkg::DEPTH_DEFAULT,
    localparam int CountW = $clog2(DEPTH + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ise_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ise_pkg::VALUE_W-1:0]        m_tdata,   // [31:0] value_res
    output logic                               m_tlast,
    output logic                               m_tuser    // [0] overflow
);
    import ise_pkg::*;

    ise_cmd_t                  cmd;
    logic [CountW-1:0]         fill_count;
    logic signed [VALUE_W-1:0] head_value;

    ise_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tlast    (s_tlast),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tlast    (m_tlast),
        .overflow   (m_tuser),
        .cmd        (cmd),
        .fill_count (fill_count)
    );

    ise_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .cmd        (cmd),
        .fill_count (fill_count),
        .in_value   ($signed(s_tdata)),
        .head_value (head_value)
    );

    assign m_tdata = $unsigned(head_value);

    // Input and output never open in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output both open");

    // While emitting, the store is never empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (fill_count != '0))
        else $error("emitting from empty store");

    // A set closes and emission starts on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("set closed without emission");

    // After the final result the engine returns empty and ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && fill_count == '0))
        else $error("engine not empty after final result");

endmodule

`default_nettype wire
